// File: hdl/stc_pkg.sv
`default_nettype none
package stc_pkg;

  // Character codes
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_NL       = 8'h0A;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_QMARK    = 8'h3F;
  localparam logic [7:0] CH_PRINT_HI = 8'h7E;

  // Column limit default and run length limit
  localparam int          MAX_COLUMN_DEF = 4095;
  localparam int          CNT_W          = 12;
  localparam logic [11:0] COUNT_MAX      = 12'hFFF;

  // Tab width register
  localparam int         TW_W        = 6;
  localparam logic [5:0] TW_RESET    = 6'd8;
  localparam logic [5:0] TW_MAX      = 6'd32;

  // Register indexes (byte address bit 2)
  localparam logic REG_TAB_WIDTH = 1'b0;
  localparam logic REG_INT_MODE  = 1'b1;

endpackage
`default_nettype wire

// File: hdl/space_to_tab_compressor_top.sv
`default_nettype none
// Space-to-tab compressor. Takes one text byte per input beat (tlast marks end of
// stream) and produces runs of (byte, repeat count): a tab run, a space run and the
// byte itself, the final beat of an input carrying tlast. Leading whitespace, or all
// whitespace when internal_mode is set, only moves a pending source column; the next
// visible byte flushes the gap. The block handles one input beat at a time. A
// converted space only moves the source column; a newline, or end of stream past
// column 0, goes straight to the byte slot. A converted tab runs the divider for
// the next stop. Any other byte then passes three emit slots (tab run, space run,
// the byte), whether the run is empty or not; a gap with conversion and a tab width
// of 2 or more is first divided, and a literal tab runs the divider for its stop.
// The divider is the shared radix-2 divider by the tab width, which yields one
// quotient bit per cycle; COL_W is the bit width of MAX_COLUMN.
// Stalls on the result side hold the emit slots. A finished result may wait in the output
// register while the next input beat is taken.
module space_to_tab_compressor_top
  import stc_pkg::*;
#(
  parameter int MAX_COLUMN = MAX_COLUMN_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] in_byte
  input  wire logic        in_tlast,   // end_of_stream
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [7:0] out_byte, [19:8] repeat_count, [23:20] zero
  output logic             out_tlast,  // last_of_run
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int COL_W = $clog2(MAX_COLUMN + 1);
  localparam int DC_W  = $clog2(COL_W);
  localparam int EXT_W = (COL_W > CNT_W) ? COL_W : CNT_W;
  localparam logic [COL_W-1:0] MAXC    = COL_W'(MAX_COLUMN);
  localparam logic [COL_W-1:0] MAXC_M1 = COL_W'(MAX_COLUMN - 1);
  localparam logic [COL_W-1:0] ONE     = COL_W'(1);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DIV    = 3'd1;
  localparam logic [2:0] S_EMIT_T = 3'd2;
  localparam logic [2:0] S_EMIT_S = 3'd3;
  localparam logic [2:0] S_EMIT_C = 3'd4;

  // divider jobs
  localparam logic [1:0] P_COL  = 2'd0;
  localparam logic [1:0] P_SRC  = 2'd1;
  localparam logic [1:0] P_STOP = 2'd2;

  function automatic logic [CNT_W-1:0] cnt_sat(input logic [COL_W-1:0] v);
    logic [EXT_W-1:0] e;
    e = EXT_W'(v);
    if (e > EXT_W'(COUNT_MAX)) cnt_sat = COUNT_MAX;
    else cnt_sat = e[CNT_W-1:0];
  endfunction

  function automatic logic [COL_W-1:0] sat_inc(input logic [COL_W-1:0] c);
    if (c >= MAXC) sat_inc = MAXC;
    else sat_inc = c + ONE;
  endfunction

  // registers
  logic [2:0]       state_r, state_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic             emit_pend_r, emit_pend_nxt;
  logic [5:0]       tw_r, tw_nxt;
  logic             mode_r, mode_nxt;
  logic             line_start_r, line_start_nxt;
  logic [COL_W-1:0] ocol_r, ocol_nxt;
  logic [COL_W-1:0] scol_r, scol_nxt;
  logic [COL_W-1:0] div_val_r, div_val_nxt;
  logic [COL_W-1:0] quo_r, quo_nxt;
  logic [5:0]       rem_r, rem_nxt;
  logic [DC_W-1:0]  dcnt_r, dcnt_nxt;
  logic [COL_W-1:0] qc_r, qc_nxt;
  logic [CNT_W-1:0] tabs_r, tabs_nxt;
  logic [CNT_W-1:0] spaces_r, spaces_nxt;
  logic [7:0]       char_r, char_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic [CNT_W-1:0] out_cnt_r, out_cnt_nxt;
  logic             out_last_r, out_last_nxt;

  // effective tab width, 1..32
  logic [5:0] w_eff;
  always_comb begin
    if (tw_r == 6'd0) w_eff = 6'd1;
    else if (tw_r > TW_MAX) w_eff = TW_MAX;
    else w_eff = tw_r;
  end

  // shared divider step: one quotient bit
  logic [6:0]       div_sh;
  logic             div_bit;
  logic [5:0]       div_rem;
  logic [COL_W-1:0] div_quo;
  always_comb begin
    div_sh  = {rem_r, quo_r[COL_W-1]};
    div_bit = (div_sh >= {1'b0, w_eff});
    div_rem = div_bit ? 6'(div_sh - {1'b0, w_eff}) : div_sh[5:0];
    div_quo = {quo_r[COL_W-2:0], div_bit};
  end

  // next tab stop from the finished division of div_val_r
  logic [COL_W:0]   stop_sum;
  logic [COL_W-1:0] stop_col;
  always_comb begin
    stop_sum = {1'b0, div_val_r} - (COL_W+1)'(div_rem) + (COL_W+1)'(w_eff);
    stop_col = (stop_sum > {1'b0, MAXC}) ? MAXC : stop_sum[COL_W-1:0];
  end

  // tab and space runs from the column and source quotients
  logic [COL_W-1:0] fl_t, fl_pos, fl_end, fl_tabs, fl_spaces;
  logic             fl_special, fl_cap;
  always_comb begin
    fl_t       = div_quo - qc_r;
    fl_special = (fl_t != '0) && ((ocol_r + ONE) == scol_r);
    fl_pos     = (fl_t != '0) ? (scol_r - COL_W'(div_rem)) : ocol_r;
    fl_cap     = (scol_r == MAXC) && (fl_pos < MAXC_M1);
    fl_end     = fl_cap ? MAXC : fl_pos;
    fl_tabs    = fl_special ? '0 : (fl_t + COL_W'(fl_cap));
    fl_spaces  = fl_special ? ONE : (scol_r - fl_end);
  end

  logic       conv, in_acc, ld, cfg_wr;
  logic [7:0] in_b, mapped;
  assign conv   = line_start_r | mode_r;
  assign in_acc = in_tvalid & in_tready;
  assign ld     = ~out_valid_r | out_tready;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite;
  assign in_b   = in_tdata;
  assign mapped = ((in_b < CH_SPACE) || (in_b > CH_PRINT_HI)) ? CH_QMARK : in_b;

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    emit_pend_nxt  = emit_pend_r;
    tw_nxt         = tw_r;
    mode_nxt       = mode_r;
    line_start_nxt = line_start_r;
    ocol_nxt       = ocol_r;
    scol_nxt       = scol_r;
    div_val_nxt    = div_val_r;
    quo_nxt        = quo_r;
    rem_nxt        = rem_r;
    dcnt_nxt       = dcnt_r;
    qc_nxt         = qc_r;
    tabs_nxt       = tabs_r;
    spaces_nxt     = spaces_r;
    char_nxt       = char_r;
    out_valid_nxt  = out_valid_r & ~out_tready;
    out_byte_nxt   = out_byte_r;
    out_cnt_nxt    = out_cnt_r;
    out_last_nxt   = out_last_r;

    // register writes
    if (cfg_wr) begin
      if (cfg_paddr[2] == REG_TAB_WIDTH) tw_nxt = cfg_pwdata[5:0];
      else mode_nxt = cfg_pwdata[0];
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          tabs_nxt   = '0;
          spaces_nxt = '0;
          if (in_tlast || in_b == CH_NL) begin
            // end of line or stream: drop pending whitespace
            char_nxt       = CH_NL;
            line_start_nxt = 1'b1;
            ocol_nxt       = '0;
            scol_nxt       = '0;
            if (!in_tlast || ocol_r != '0) state_nxt = S_EMIT_C;
          end else if (in_b == CH_SPACE && conv) begin
            scol_nxt = sat_inc(scol_r);
          end else if (in_b == CH_TAB && conv) begin
            // advance source column to next stop
            div_val_nxt   = scol_r;
            quo_nxt       = scol_r;
            rem_nxt       = '0;
            dcnt_nxt      = DC_W'(COL_W - 1);
            phase_nxt     = P_STOP;
            emit_pend_nxt = 1'b0;
            state_nxt     = S_DIV;
          end else begin
            char_nxt = (in_b == CH_TAB) ? CH_TAB : mapped;
            if (conv && ocol_r < scol_r && w_eff != 6'd1) begin
              // converted gap: divide both columns by tab width
              div_val_nxt = ocol_r;
              quo_nxt     = ocol_r;
              rem_nxt     = '0;
              dcnt_nxt    = DC_W'(COL_W - 1);
              phase_nxt   = P_COL;
              state_nxt   = S_DIV;
            end else begin
              logic [COL_W-1:0] colf;
              colf = (ocol_r < scol_r) ? scol_r : ocol_r;
              if (ocol_r < scol_r) begin
                if (conv) begin
                  tabs_nxt   = cnt_sat(scol_r - ocol_r - ONE);
                  spaces_nxt = CNT_W'(1);
                end else begin
                  spaces_nxt = cnt_sat(scol_r - ocol_r);
                end
              end
              if (in_b == CH_TAB) begin
                // literal tab: output column moves to next stop
                div_val_nxt   = colf;
                quo_nxt       = colf;
                rem_nxt       = '0;
                dcnt_nxt      = DC_W'(COL_W - 1);
                phase_nxt     = P_STOP;
                emit_pend_nxt = 1'b1;
                state_nxt     = S_DIV;
              end else begin
                ocol_nxt  = sat_inc(colf);
                scol_nxt  = sat_inc(colf);
                if (mapped != CH_SPACE) line_start_nxt = 1'b0;
                state_nxt = S_EMIT_T;
              end
            end
          end
        end
      end

      S_DIV: begin
        quo_nxt  = div_quo;
        rem_nxt  = div_rem;
        dcnt_nxt = dcnt_r - DC_W'(1);
        if (dcnt_r == '0) begin
          unique case (phase_r)
            P_COL: begin
              qc_nxt      = div_quo;
              div_val_nxt = scol_r;
              quo_nxt     = scol_r;
              rem_nxt     = '0;
              dcnt_nxt    = DC_W'(COL_W - 1);
              phase_nxt   = P_SRC;
            end
            P_SRC: begin
              tabs_nxt       = cnt_sat(fl_tabs);
              spaces_nxt     = cnt_sat(fl_spaces);
              ocol_nxt       = sat_inc(scol_r);
              scol_nxt       = sat_inc(scol_r);
              if (char_r != CH_SPACE) line_start_nxt = 1'b0;
              state_nxt      = S_EMIT_T;
            end
            P_STOP: begin
              scol_nxt = stop_col;
              if (emit_pend_r) begin
                ocol_nxt  = stop_col;
                state_nxt = S_EMIT_T;
              end else begin
                state_nxt = S_IDLE;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      S_EMIT_T: begin
        if (tabs_r == '0) begin
          state_nxt = S_EMIT_S;
        end else if (ld) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = CH_TAB;
          out_cnt_nxt   = tabs_r;
          out_last_nxt  = 1'b0;
          state_nxt     = S_EMIT_S;
        end
      end

      S_EMIT_S: begin
        if (spaces_r == '0) begin
          state_nxt = S_EMIT_C;
        end else if (ld) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = CH_SPACE;
          out_cnt_nxt   = spaces_r;
          out_last_nxt  = 1'b0;
          state_nxt     = S_EMIT_C;
        end
      end

      S_EMIT_C: begin
        if (ld) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = char_r;
          out_cnt_nxt   = CNT_W'(1);
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      phase_r      <= P_COL;
      emit_pend_r  <= 1'b0;
      tw_r         <= TW_RESET;
      mode_r       <= 1'b0;
      line_start_r <= 1'b1;
      ocol_r       <= '0;
      scol_r       <= '0;
      dcnt_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      emit_pend_r  <= emit_pend_nxt;
      tw_r         <= tw_nxt;
      mode_r       <= mode_nxt;
      line_start_r <= line_start_nxt;
      ocol_r       <= ocol_nxt;
      scol_r       <= scol_nxt;
      dcnt_r       <= dcnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    div_val_r  <= div_val_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    qc_r       <= qc_nxt;
    tabs_r     <= tabs_nxt;
    spaces_r   <= spaces_nxt;
    char_r     <= char_nxt;
    out_byte_r <= out_byte_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_cnt_r, out_byte_r};
  assign out_tlast  = out_last_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_INT_MODE) ? {31'b0, mode_r} : {26'b0, tw_r};

endmodule
`default_nettype wire

// File: verif/space_to_tab_compressor_top_tb.sv
module space_to_tab_compressor_top_tb;
  import stc_pkg::*;

  localparam int COL_LIMIT = 4095;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [7:0]  ch;
    logic [11:0] count;
    logic        last;
  } run_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;    // [7:0] in_byte
  logic        in_tlast = 1'b0;  // end_of_stream
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;        // [7:0] out_byte, [19:8] repeat_count, [23:20] zero
  logic        out_tlast;        // last_of_run
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // shadow of the block's registers and line state
  logic [5:0]  tw_shadow = TW_RESET;
  logic        imode_shadow = 1'b0;
  logic        line_fresh = 1'b1;
  int          out_col = 0;
  int          src_col = 0;

  run_t        expected_runs[$];
  int          fail_count = 0;
  int          items_sent = 0;
  int          tx_idle_pct = 27;
  int          rx_idle_pct = 46;
  int          hold_reqs = 0;
  int          hold_done = 0;
  int          hold_left = 0;

  space_to_tab_compressor_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #2 clk = ~clk;

  // tab width as the block uses it: zero acts as 1, above 32 acts as 32
  function automatic int stop_width();
    if (tw_shadow == 6'd0) return 1;
    if (tw_shadow > TW_MAX) return int'(TW_MAX);
    return int'(tw_shadow);
  endfunction

  function automatic int next_tab_stop(input int c);
    int w;
    int k;
    w = stop_width();
    k = (c / w + 1) * w;
    return (k > COL_LIMIT) ? COL_LIMIT : k;
  endfunction

  function automatic int col_step(input int c);
    return (c >= COL_LIMIT) ? COL_LIMIT : c + 1;
  endfunction

  function automatic void push_run(ref run_t runs[$], input logic [7:0] ch, input int n);
    run_t r;
    r.ch = ch;
    r.count = (n > int'(COUNT_MAX)) ? COUNT_MAX : n[11:0];
    r.last = 1'b0;
    runs.push_back(r);
  endfunction

  // work out the runs one accepted beat causes and queue them
  function automatic void entab_predict(input logic [7:0] b, input logic eos);
    run_t runs[$];
    logic conv;
    logic [7:0] ch;
    int col;
    int tabs;
    int spaces;
    conv = line_fresh || imode_shadow;
    if (eos) begin
      if (out_col != 0) push_run(runs, CH_NL, 1);
      line_fresh = 1'b1;
      out_col = 0;
      src_col = 0;
    end else if (b == CH_NL) begin
      push_run(runs, CH_NL, 1);
      line_fresh = 1'b1;
      out_col = 0;
      src_col = 0;
    end else if (b == CH_SPACE && conv) begin
      src_col = col_step(src_col);
    end else if (b == CH_TAB && conv) begin
      src_col = next_tab_stop(src_col);
    end else begin
      col = out_col;
      tabs = 0;
      spaces = 0;
      // fill the gap with tabs where a stop is reachable, then spaces
      while (col < src_col) begin
        if (col + 1 < src_col && conv && next_tab_stop(col) <= src_col) begin
          tabs++;
          col = next_tab_stop(col);
        end else begin
          spaces++;
          col++;
        end
      end
      if (tabs != 0) push_run(runs, CH_TAB, tabs);
      if (spaces != 0) push_run(runs, CH_SPACE, spaces);
      if (b == CH_TAB) begin
        push_run(runs, CH_TAB, 1);
        col = next_tab_stop(col);
      end else begin
        ch = (b < CH_SPACE || b > CH_PRINT_HI) ? CH_QMARK : b;
        if (ch != CH_SPACE) line_fresh = 1'b0;
        push_run(runs, ch, 1);
        col = col_step(col);
      end
      out_col = col;
      src_col = col;
    end
    if (runs.size() != 0) runs[runs.size() - 1].last = 1'b1;
    foreach (runs[i]) expected_runs.push_back(runs[i]);
  endfunction

  // offer one beat, optionally after a gap, and predict it once accepted
  task automatic send_item(input logic [7:0] b, input logic eos);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= eos;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    entab_predict(b, eos);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  // drop valid, wait for every expected run, then let a pending conversion finish
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_runs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic idx, input logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (idx == REG_TAB_WIDTH) tw_shadow = val[5:0];
    else imode_shadow = val[0];
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [5:0] width, input logic mode);
    drain();
    reg_write(REG_TAB_WIDTH, {26'd0, width});
    reg_write(REG_INT_MODE, {31'd0, mode});
  endtask

  // drop valid so the last beat is not taken twice, then switch idling
  task automatic set_idle(input int tx_pct, input int rx_pct);
    in_tvalid <= 1'b0;
    tx_idle_pct <= tx_pct;
    rx_idle_pct <= rx_pct;
    @(posedge clk);
  endtask

  // leading whitespace, literal tabs and spaces, unprintable bytes, blank lines
  task automatic test_leading_default();
    send_text("  \tab\tc d");
    send_item(8'h00, 1'b0);
    send_item(8'h7F, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h7E, 1'b0);
    send_item(CH_NL, 1'b0);
    send_text("   ");
    send_item(CH_NL, 1'b0);
    send_text(" \t");
    send_item(8'hA5, 1'b1);
    send_item(8'h00, 1'b1);
    send_text("x");
    send_item(8'h5A, 1'b1);
  endtask

  // internal mode at width 1 and 0 (gaps become tabs and one space), then width 63 without it
  task automatic test_internal_mode();
    set_config(6'd1, 1'b1);
    send_text(" \tx  \ty");
    send_item(CH_NL, 1'b0);
    set_config(6'd0, 1'b1);
    send_text("  a ");
    send_item(CH_NL, 1'b0);
    set_config(6'd63, 1'b0);
    send_text("\t  b\t c");
    send_item(8'h00, 1'b1);
  endtask

  // push both columns to their limit with leading tabs at width 32
  task automatic test_column_limit();
    set_config(TW_MAX, 1'b0);
    for (int i = 0; i < 130; i++) send_item(CH_TAB, 1'b0);
    send_text("ab\t c");
    send_item(CH_NL, 1'b0);
  endtask

  // hold the result side off while the input keeps offering visible bytes
  task automatic test_output_hold();
    drain();
    set_idle(0, 0);
    hold_reqs <= hold_reqs + 1;
    for (int i = 0; i < 30; i++) send_item(8'($urandom_range(8'h21, 8'h7E)), 1'b0);
    send_item(CH_NL, 1'b0);
  endtask

  task automatic random_config();
    int pick;
    logic [5:0] w;
    pick = $urandom_range(9);
    if (pick == 0) w = 6'd0;
    else if (pick == 1) w = 6'($urandom_range(33, 63));
    else w = 6'($urandom_range(1, 32));
    set_config(w, 1'($urandom_range(1)));
  endtask

  task automatic send_gap(input int lo, input int hi);
    repeat ($urandom_range(lo, hi)) send_item($urandom_range(1) ? CH_SPACE : CH_TAB, 1'b0);
  endtask

  // lines of words with random whitespace, some noise, then newline, end of stream or neither
  task automatic test_random_text(input int count, input int tx_pct, input int rx_pct);
    int stop_at;
    int words;
    int ending;
    stop_at = items_sent + count;
    set_idle(tx_pct, rx_pct);
    while (items_sent < stop_at) begin
      if ($urandom_range(5) == 0) random_config();
      send_gap(0, 6);
      words = $urandom_range(0, 4);
      for (int w = 0; w < words; w++) begin
        if (w != 0) send_gap(1, 4);
        repeat ($urandom_range(1, 5)) begin
          if ($urandom_range(11) == 0) send_item(8'($urandom_range(255)), 1'b0);
          else send_item(8'($urandom_range(8'h21, 8'h7E)), 1'b0);
        end
      end
      if ($urandom_range(3) == 0) send_gap(1, 3);
      ending = $urandom_range(19);
      if (ending < 16) send_item(CH_NL, 1'b0);
      else if (ending < 18) send_item(8'($urandom_range(255)), 1'b1);
    end
  endtask

  // result side: random stalls, plus a long hold on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_done != hold_reqs) begin
      hold_done <= hold_done + 1;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // compare each result beat with the oldest expected run
  always @(posedge clk) begin : check_runs
    run_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_runs.size() == 0) begin
        $error("unexpected result beat: byte %0h count %0d", out_tdata[7:0], out_tdata[19:8]);
        fail_count++;
      end else begin
        want = expected_runs.pop_front();
        if (out_tdata[7:0] !== want.ch) begin
          $error("out_byte: expected %0h, got %0h", want.ch, out_tdata[7:0]);
          fail_count++;
        end
        if (out_tdata[19:8] !== want.count) begin
          $error("repeat_count: expected %0d, got %0d", want.count, out_tdata[19:8]);
          fail_count++;
        end
        if (out_tdata[23:20] !== 4'd0) begin
          $error("tdata pad: expected 0, got %0h", out_tdata[23:20]);
          fail_count++;
        end
        if (out_tlast !== want.last) begin
          $error("last_of_run: expected %0b, got %0b", want.last, out_tlast);
          fail_count++;
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    test_leading_default();
    test_internal_mode();
    set_idle(46, 27);
    test_column_limit();
    test_output_hold();
    test_random_text(50, 27, 46);
    test_random_text(50, 46, 27);
    test_random_text(50, 0, 0);
    drain();
    if (fail_count == 0) begin
      $display("space_to_tab_compressor_top test passed");
    end else begin
      $display("space_to_tab_compressor_top test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("space_to_tab_compressor_top test failed");
    $finish;
  end

endmodule

// File: files.f
hdl/stc_pkg.sv
hdl/space_to_tab_compressor_top.sv
verif/space_to_tab_compressor_top_tb.sv
